### sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// Paragraph chunk splitter package
// Shared constants, register indexes, character codes and the operation set
// that travels from the byte classifier to the chunk engine.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_LEN = 8'd1;
  localparam logic [CFG_W-1:0]     MAX_LEN_RST     = 16'd2048;
  localparam logic [CFG_W-1:0]     MIN_LEN_RST     = 16'd64;

  // Default widths and fixed sizes
  localparam int DEF_OFFSET_WIDTH = 32;
  localparam int DEF_LENGTH_WIDTH = 16;
  localparam int COUNT_W          = 32;
  localparam int MAX_RESULTS      = 3;
  localparam int JOB_DEPTH        = 4;
  localparam int RES_DEPTH        = 4;

  // Characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Result kinds
  localparam logic KIND_CHUNK   = 1'b0;
  localparam logic KIND_DOC_END = 1'b1;

  // Operations raised by one byte. They run in order from the least
  // significant member upward, so the first operation is a_prev.
  typedef struct packed {
    logic doc_end;  // report the document end and clear all counters
    logic f_end;    // close the paragraph at the position after this byte
    logic a_pos;    // this byte joins the paragraph
    logic start;    // a paragraph opens at this byte
    logic f_prev;   // close the paragraph before a held-back newline
    logic a_prev;   // a held-back newline joins the paragraph
  } pcs_ops_t;

endpackage

### sv/paragraph_chunk_splitter_unit.sv
// ----------------------------------------------------------------------------
// Paragraph chunk splitter
// Cuts a byte stream into paragraph chunks and reports offset, length and
// number of each kept chunk, plus a document-end beat with the total.
// ----------------------------------------------------------------------------
// Path: a byte's operations wait in the job queue for the engine; each result
//   is held in the engine's pending register, then queued for the out_ ports.
// Throughput: one byte per cycle while the job queue has room. The engine
//   runs one operation per cycle unless the result queue is full: ordinary
//   bytes need one or none, a byte after a held-back newline up to two, and
//   the last byte of a document up to four.
// Reset: synchronous, active low; counters and flags clear, both queues
//   empty, max_chunk_len returns to 2048 and min_chunk_len to 64.
// ----------------------------------------------------------------------------
module paragraph_chunk_splitter_unit #(
  parameter int OFFSET_WIDTH = pcs_pkg::DEF_OFFSET_WIDTH,
  parameter int LENGTH_WIDTH = pcs_pkg::DEF_LENGTH_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Byte input
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  // Result output
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_result_kind,
  output logic [OFFSET_WIDTH-1:0]       out_chunk_offset,
  output logic [LENGTH_WIDTH-1:0]       out_chunk_length,
  output logic [pcs_pkg::COUNT_W-1:0]   out_chunk_number,
  output logic [pcs_pkg::COUNT_W-1:0]   out_total_chunks,
  output logic                          out_run_last,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcs_pkg::CFG_W-1:0]     cfg_data
);

  localparam int OPS_W = $bits(pcs_pkg::pcs_ops_t);
  localparam int JOB_W = 1 + OPS_W + 2 * OFFSET_WIDTH;
  localparam int RES_W = 2 + OFFSET_WIDTH + LENGTH_WIDTH + 2 * pcs_pkg::COUNT_W;

  // Configuration registers. Writes are always taken; an index outside
  // the register list is ignored.
  logic [pcs_pkg::CFG_W-1:0] max_len_r, max_len_nxt;
  logic [pcs_pkg::CFG_W-1:0] min_len_r, min_len_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    min_len_nxt = min_len_r;
    if (cfg_valid) begin
      case (cfg_index)
        pcs_pkg::CFG_IDX_MAX_LEN: max_len_nxt = cfg_data;
        pcs_pkg::CFG_IDX_MIN_LEN: min_len_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= pcs_pkg::MAX_LEN_RST;
      min_len_r <= pcs_pkg::MIN_LEN_RST;
    end else begin
      max_len_r <= max_len_nxt;
      min_len_r <= min_len_nxt;
    end
  end

  // Front end: classifies each byte against the paragraph rules and emits
  // the list of chunk operations it triggers. Bytes that trigger nothing,
  // such as whitespace between paragraphs, do not enter the queue.
  logic                    job_push, job_full, job_empty, job_pop;
  logic [OFFSET_WIDTH-1:0] f_pos, f_pos_next, b_pos, b_pos_next;
  logic                    f_cand, b_cand;
  pcs_pkg::pcs_ops_t       f_ops, b_ops;
  logic [JOB_W-1:0]        job_wr_data, job_rd_data;

  pcs_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_full      (in_full),
    .job_full     (job_full),
    .job_push     (job_push),
    .job_pos      (f_pos),
    .job_pos_next (f_pos_next),
    .job_cand     (f_cand),
    .job_ops      (f_ops)
  );

  // Job queue between the classifier and the chunk engine. It absorbs the
  // extra engine cycles of newline and end-of-document bytes.
  assign job_wr_data = {f_cand, f_ops, f_pos_next, f_pos};
  assign {b_cand, b_ops, b_pos_next, b_pos} = job_rd_data;

  pcs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (pcs_pkg::JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wr_data),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd_data),
    .empty   (job_empty)
  );

  // Back end: runs the operations against the chunk start, cut point and
  // chunk count and forms the result beats.
  logic             res_wr, res_full;
  logic [RES_W-1:0] res_wr_data, res_rd_data;

  pcs_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .RES_W        (RES_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!job_empty),
    .job_pos      (b_pos),
    .job_pos_next (b_pos_next),
    .job_cand     (b_cand),
    .job_ops      (b_ops),
    .job_pop      (job_pop),
    .max_len      (max_len_r),
    .min_len      (min_len_r),
    .res_full     (res_full),
    .res_wr       (res_wr),
    .res_data     (res_wr_data)
  );

  // Result queue; its head drives the output ports directly.
  pcs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (pcs_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rd_data),
    .empty   (out_empty)
  );

  assign {out_run_last, out_result_kind, out_chunk_offset, out_chunk_length,
          out_chunk_number, out_total_chunks} = res_rd_data;

endmodule

### sv/pcs_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Holds beats between two parts of the splitter so each side stalls alone.
// ----------------------------------------------------------------------------
module pcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/pcs_front.sv
// ----------------------------------------------------------------------------
// Splitter byte classifier
// Tracks position, paragraph and held-newline state and turns each byte into
// a set of chunk operations for the engine.
// ----------------------------------------------------------------------------
module pcs_front #(
  parameter int OFFSET_WIDTH = pcs_pkg::DEF_OFFSET_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_last_byte,
  output logic                    in_full,
  input  logic                    job_full,
  output logic                    job_push,
  output logic [OFFSET_WIDTH-1:0] job_pos,
  output logic [OFFSET_WIDTH-1:0] job_pos_next,
  output logic                    job_cand,
  output pcs_pkg::pcs_ops_t       job_ops
);

  logic [OFFSET_WIDTH-1:0] byte_pos_r, byte_pos_nxt;
  logic                    in_para_r, in_para_nxt;
  logic                    prev_nl_r, prev_nl_nxt;
  logic                    accept;
  logic                    is_ws;
  logic                    ended;
  pcs_pkg::pcs_ops_t       ops;

  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  assign is_ws = in_data_byte inside {pcs_pkg::CH_LF, pcs_pkg::CH_CR,
                                      pcs_pkg::CH_SPACE, pcs_pkg::CH_TAB};

  // The position counter sticks at its top value.
  assign job_pos      = byte_pos_r;
  assign job_pos_next = (byte_pos_r == {OFFSET_WIDTH{1'b1}}) ? byte_pos_r
                                                             : byte_pos_r + OFFSET_WIDTH'(1);
  assign job_cand     = (in_data_byte == pcs_pkg::CH_LF) || (in_data_byte == pcs_pkg::CH_DOT);

  always_comb begin
    ops          = '0;
    ended        = 1'b0;
    in_para_nxt  = in_para_r;
    prev_nl_nxt  = prev_nl_r;
    byte_pos_nxt = job_pos_next;

    if (in_para_r) begin
      if (prev_nl_r) begin
        prev_nl_nxt = 1'b0;
        if (in_data_byte inside {pcs_pkg::CH_LF, pcs_pkg::CH_CR}) begin
          ops.f_prev  = 1'b1;
          ended       = 1'b1;
          in_para_nxt = 1'b0;
        end else begin
          ops.a_prev = 1'b1;
        end
      end
      if (!ended) begin
        if (in_data_byte == pcs_pkg::CH_LF) begin
          prev_nl_nxt = 1'b1;
        end else begin
          ops.a_pos = 1'b1;
        end
      end
    end else if (!is_ws) begin
      // The first admit of a paragraph can neither cut nor mark a cut point.
      ops.start   = 1'b1;
      in_para_nxt = 1'b1;
      prev_nl_nxt = 1'b0;
    end

    if (in_last_byte) begin
      if (in_para_nxt) begin
        if (prev_nl_nxt) begin
          ops.a_pos = 1'b1;
        end
        ops.f_end = 1'b1;
      end
      ops.doc_end  = 1'b1;
      byte_pos_nxt = '0;
      in_para_nxt  = 1'b0;
      prev_nl_nxt  = 1'b0;
    end
  end

  assign job_ops  = ops;
  assign job_push = accept && (ops != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      in_para_r  <= 1'b0;
      prev_nl_r  <= 1'b0;
    end else if (accept) begin
      byte_pos_r <= byte_pos_nxt;
      in_para_r  <= in_para_nxt;
      prev_nl_r  <= prev_nl_nxt;
    end
  end

endmodule

### sv/pcs_back.sv
// ----------------------------------------------------------------------------
// Splitter chunk engine
// Runs queued operations one per cycle while the result queue has room, holds
// the chunk start, cut point and chunk count, and forms result beats with
// their run_last marks.
module pcs_back #(
  parameter int OFFSET_WIDTH = pcs_pkg::DEF_OFFSET_WIDTH,
  parameter int LENGTH_WIDTH = pcs_pkg::DEF_LENGTH_WIDTH,
  parameter int RES_W        = 2 + OFFSET_WIDTH + LENGTH_WIDTH + 2 * pcs_pkg::COUNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  input  logic [OFFSET_WIDTH-1:0]  job_pos,
  input  logic [OFFSET_WIDTH-1:0]  job_pos_next,
  input  logic                     job_cand,
  input  pcs_pkg::pcs_ops_t        job_ops,
  output logic                     job_pop,
  input  logic [pcs_pkg::CFG_W-1:0] max_len,
  input  logic [pcs_pkg::CFG_W-1:0] min_len,
  input  logic                     res_full,
  output logic                     res_wr,
  output logic [RES_W-1:0]         res_data
);

  localparam int OW    = OFFSET_WIDTH;
  localparam int LW    = LENGTH_WIDTH;
  localparam int CW    = pcs_pkg::COUNT_W;
  localparam int NOPS  = $bits(pcs_pkg::pcs_ops_t);
  localparam int XW0   = (OW > LW) ? OW : LW;
  localparam int XW    = (XW0 > pcs_pkg::CFG_W) ? XW0 : pcs_pkg::CFG_W;
  localparam int RCW   = $clog2(pcs_pkg::MAX_RESULTS + 1);
  localparam int BODY_W = RES_W - 1;

  logic [OW-1:0]     chunk_start_r, chunk_start_nxt;
  logic [LW-1:0]     cut_cand_r, cut_cand_nxt;
  logic              cut_found_r, cut_found_nxt;
  logic [CW-1:0]     chunks_r, chunks_nxt;
  logic [RCW-1:0]    res_cnt_r, res_cnt_nxt;
  logic [NOPS-1:0]   done_r, done_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              pend_fin_r, pend_fin_nxt;
  logic [BODY_W-1:0] pend_body_r, pend_body_nxt;

  logic [NOPS-1:0]   rem, sel;
  pcs_pkg::pcs_ops_t op;
  logic              go, proc, is_last;
  logic [OW-1:0]     k_prev, k_pos, k_end, k_sel;
  logic [XW-1:0]     m_x, dist_x, cut_x, keep_len_x, cfg_max_x, len_top_x;
  logic [LW-1:0]     m_l;
  logic              is_adm, is_fin, cand_eff, cut_hit, use_cand, keep, res_gen, res_ok;
  logic [CW-1:0]     chunks_inc;
  logic [BODY_W-1:0] new_body;
  logic              rl_out;

  // Effective maximum: the register clamped to 2 .. 2^LW-1.
  assign cfg_max_x = XW'(max_len);
  assign len_top_x = XW'({LW{1'b1}});
  assign m_x = (cfg_max_x < XW'(2)) ? XW'(2) :
               (cfg_max_x > len_top_x) ? len_top_x : cfg_max_x;
  assign m_l = LW'(m_x);

  // Pick the next pending operation of the head job.
  assign rem     = job_ops & ~done_r;
  assign sel     = rem & (~rem + NOPS'(1));
  assign op      = pcs_pkg::pcs_ops_t'(sel);
  assign is_last = ((rem & ~sel) == '0);
  assign go      = !res_full;
  assign proc    = go && job_valid && (rem != '0);
  assign job_pop = proc && is_last;

  // Distances from the chunk start. pos + ~start is pos - start - 1, the
  // distance of the held-back newline one byte earlier.
  assign k_prev = (job_pos > chunk_start_r) ? job_pos + ~chunk_start_r : '0;
  assign k_pos  = (job_pos >= chunk_start_r) ? job_pos - chunk_start_r : '0;
  assign k_end  = (job_pos_next >= chunk_start_r) ? job_pos_next - chunk_start_r : '0;
  assign k_sel  = (op.a_prev || op.f_prev) ? k_prev : (op.f_end ? k_end : k_pos);
  assign dist_x = XW'(k_sel);

  assign is_adm   = op.a_prev || op.a_pos;
  assign is_fin   = op.f_prev || op.f_end;
  assign cand_eff = op.a_prev || job_cand;
  assign cut_hit  = is_adm && (dist_x >= m_x);
  assign use_cand = !cand_eff && cut_found_r && (cut_cand_r < m_l);
  assign cut_x    = use_cand ? XW'(cut_cand_r) : m_x;
  assign keep_len_x = cut_hit ? cut_x : dist_x;
  assign keep     = (cut_hit || is_fin) && (keep_len_x >= XW'(min_len));
  assign res_gen  = keep || op.doc_end;
  assign res_ok   = res_gen && (res_cnt_r < RCW'(pcs_pkg::MAX_RESULTS));

  assign chunks_inc = (chunks_r == {CW{1'b1}}) ? chunks_r : chunks_r + CW'(1);

  always_comb begin
    if (op.doc_end) begin
      new_body = {pcs_pkg::KIND_DOC_END, OW'(0), LW'(0), CW'(0), chunks_r};
    end else begin
      new_body = {pcs_pkg::KIND_CHUNK, chunk_start_r, LW'(keep_len_x), chunks_inc, chunks_inc};
    end
  end

  // Chunk state.
  always_comb begin
    chunk_start_nxt = chunk_start_r;
    cut_cand_nxt    = cut_cand_r;
    cut_found_nxt   = cut_found_r;
    chunks_nxt      = chunks_r;
    res_cnt_nxt     = res_cnt_r;
    done_nxt        = done_r;
    if (proc) begin
      done_nxt    = is_last ? '0 : (done_r | sel);
      res_cnt_nxt = is_last ? '0 : (res_ok ? res_cnt_r + RCW'(1) : res_cnt_r);
      if (keep) begin
        chunks_nxt = chunks_inc;
      end
      if (op.start) begin
        chunk_start_nxt = job_pos;
        cut_cand_nxt    = '0;
        cut_found_nxt   = 1'b0;
      end else if (cut_hit) begin
        chunk_start_nxt = OW'(XW'(chunk_start_r) + cut_x);
        cut_cand_nxt    = '0;
        cut_found_nxt   = 1'b0;
      end else if (is_adm && cand_eff && (dist_x > (m_x >> 1))) begin
        cut_cand_nxt  = LW'(k_sel);
        cut_found_nxt = 1'b1;
      end else if (is_fin) begin
        cut_cand_nxt  = '0;
        cut_found_nxt = 1'b0;
      end else if (op.doc_end) begin
        chunk_start_nxt = '0;
        cut_cand_nxt    = '0;
        cut_found_nxt   = 1'b0;
        chunks_nxt      = '0;
      end
    end
  end

  // One result is held back until it is known whether it is the last one
  // of its byte; at most one beat leaves per cycle.
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_fin_nxt  = pend_fin_r;
    pend_body_nxt = pend_body_r;
    res_wr        = 1'b0;
    rl_out        = pend_fin_r;
    if (proc && res_ok) begin
      res_wr        = pend_v_r;
      pend_v_nxt    = 1'b1;
      pend_fin_nxt  = is_last;
      pend_body_nxt = new_body;
    end else if (proc && is_last) begin
      res_wr     = pend_v_r;
      rl_out     = 1'b1;
      pend_v_nxt = 1'b0;
    end else if (go && pend_v_r && pend_fin_r) begin
      res_wr     = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  assign res_data = {rl_out, pend_body_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_start_r <= '0;
      cut_cand_r    <= '0;
      cut_found_r   <= 1'b0;
      chunks_r      <= '0;
      res_cnt_r     <= '0;
      done_r        <= '0;
      pend_v_r      <= 1'b0;
      pend_fin_r    <= 1'b0;
    end else begin
      chunk_start_r <= chunk_start_nxt;
      cut_cand_r    <= cut_cand_nxt;
      cut_found_r   <= cut_found_nxt;
      chunks_r      <= chunks_nxt;
      res_cnt_r     <= res_cnt_nxt;
      done_r        <= done_nxt;
      pend_v_r      <= pend_v_nxt;
      pend_fin_r    <= pend_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_body_r <= pend_body_nxt;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paragraph chunk splitter testbench
// Feeds byte streams through the splitter and scores every result beat
// against a cycle-free model of the chunking rules kept inside the bench.
// A short table of hand-picked bytes and register writes runs first, then
// phases of random text under a range of length limits.
// ----------------------------------------------------------------------------
module tb;

  // One result beat as it appears on the out_ ports.
  typedef struct packed {
    logic        kind;
    logic [31:0] offset;
    logic [15:0] length;
    logic [31:0] number;
    logic [31:0] total;
    logic        run_last;
  } chunk_beat_t;

  // How a stimulus row is scored. Most bytes go through the chunk model;
  // a few rows carry their outcome typed in, and one kind writes a register.
  typedef enum logic [1:0] {
    ROW_MODEL,    // expected beats come from the chunk model
    ROW_QUIET,    // the byte must cause no beat at all
    ROW_DOC_END,  // exactly one document-end beat with the typed total
    ROW_CFG       // register write: code is the index, value the data
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  code;
    logic        last;
    logic [15:0] value;
  } stim_row_t;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  // A last byte runs up to four engine operations, so this wait after the
  // owed beats are gone leaves plenty of margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 120;
  localparam int RANDOM_PHASES = 8;
  localparam int LIMIT_NS      = 5000000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic                          in_full;
  logic [7:0]                    in_data_byte;
  logic                          in_last_byte;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic                          out_result_kind;
  logic [31:0]                   out_chunk_offset;
  logic [15:0]                   out_chunk_length;
  logic [pcs_pkg::COUNT_W-1:0]   out_chunk_number;
  logic [pcs_pkg::COUNT_W-1:0]   out_total_chunks;
  logic                          out_run_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcs_pkg::CFG_W-1:0]     cfg_data;

  // Scoring tag that travels alongside the byte on the input port.
  row_kind_e   drv_kind;
  logic [15:0] drv_total;

  paragraph_chunk_splitter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_kind  (out_result_kind),
    .out_chunk_offset (out_chunk_offset),
    .out_chunk_length (out_chunk_length),
    .out_chunk_number (out_chunk_number),
    .out_total_chunks (out_total_chunks),
    .out_run_last     (out_run_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Chunk model state. Positions are kept in 64 bits so that the saturation
  // compare against 2^32-1 is exact.
  // --------------------------------------------------------------------------
  bit [15:0]   span_max  = pcs_pkg::MAX_LEN_RST;   // max_chunk_len as last written
  bit [15:0]   keep_min  = pcs_pkg::MIN_LEN_RST;   // min_chunk_len as last written
  bit [63:0]   pos_count;                 // bytes seen in this document
  bit [63:0]   chunk_base;                // offset where the open chunk began
  bit          in_para;                   // inside a paragraph
  bit          held_lf;                   // an LF waits for its lookahead byte
  bit [63:0]   cut_at;                    // latest cut point past half the max
  bit          cut_valid;
  bit [63:0]   chunks_kept;

  chunk_beat_t step_beats[$];             // beats caused by the current byte
  chunk_beat_t pending_chunks[$];         // beats the DUT still owes us

  int failures    = 0;
  int bytes_taken = 0;
  int docs_ended  = 0;
  int beats_seen  = 0;
  int reg_writes  = 0;
  int pop_mode    = 0;
  int pop_epoch   = 0;
  int pop_tick    = 0;

  function automatic void clear_document();
    pos_count   = 0;
    chunk_base  = 0;
    in_para     = 0;
    held_lf     = 0;
    cut_at      = 0;
    cut_valid   = 0;
    chunks_kept = 0;
  endfunction

  // The length limit is clamped from below to 2; the top of the 16-bit
  // field already equals 2^LENGTH_WIDTH-1, so no upper clamp is needed.
  function automatic bit [63:0] span_limit();
    return (span_max < 16'd2) ? 64'd2 : 64'(span_max);
  endfunction

  function automatic void add_beat(logic kind, bit [63:0] off, bit [63:0] len,
                                   bit [63:0] num, bit [63:0] total);
    chunk_beat_t b;
    if (step_beats.size() >= pcs_pkg::MAX_RESULTS) return;
    b.kind     = kind;
    b.offset   = off[31:0];
    b.length   = len[15:0];
    b.number   = num[31:0];
    b.total    = total[31:0];
    b.run_last = 1'b0;
    step_beats.push_back(b);
  endfunction

  // Short chunks vanish without taking a number.
  function automatic void keep_chunk(bit [63:0] off, bit [63:0] len);
    if (len < 64'(keep_min)) return;
    if (chunks_kept < 64'hFFFF_FFFF) chunks_kept++;
    add_beat(pcs_pkg::KIND_CHUNK, off, len, chunks_kept, chunks_kept);
  endfunction

  // Byte b at position p is known to be part of the paragraph.
  function automatic void admit_byte(bit [63:0] p, logic [7:0] b);
    bit [63:0] m;
    bit [63:0] k;
    bit [63:0] cut;
    bit        cand;
    m    = span_limit();
    k    = (p >= chunk_base) ? p - chunk_base : 64'd0;
    cand = (b == pcs_pkg::CH_DOT) || (b == pcs_pkg::CH_LF);
    if (k >= m) begin
      // A stored cut point at or beyond a freshly lowered max is stale.
      cut = m;
      if (!cand && cut_valid && cut_at < m) cut = cut_at;
      keep_chunk(chunk_base, cut);
      chunk_base += cut;
      cut_valid = 0;
      cut_at    = 0;
    end else if (cand && k > m / 2) begin
      cut_at    = k;
      cut_valid = 1;
    end
  endfunction

  function automatic void close_para(bit [63:0] endpos);
    keep_chunk(chunk_base, (endpos >= chunk_base) ? endpos - chunk_base : 64'd0);
    in_para   = 0;
    held_lf   = 0;
    cut_valid = 0;
    cut_at    = 0;
  endfunction

  // Works out every beat one accepted byte causes; leaves them in step_beats.
  function automatic void split_byte(logic [7:0] b, logic last);
    bit [63:0]   p;
    bit [63:0]   prev;
    bit          ws;
    bit          closed;
    chunk_beat_t tail;
    p      = pos_count;
    ws     = (b == pcs_pkg::CH_LF) || (b == pcs_pkg::CH_CR) ||
             (b == pcs_pkg::CH_SPACE) || (b == pcs_pkg::CH_TAB);
    closed = 0;
    step_beats.delete();
    if (in_para) begin
      if (held_lf) begin
        // The held LF is settled by this byte: a second line break ends
        // the paragraph before the LF, anything else pulls the LF in.
        prev    = (p > chunk_base) ? p - 1 : chunk_base;
        held_lf = 0;
        if (b == pcs_pkg::CH_LF || b == pcs_pkg::CH_CR) begin
          close_para(prev);
          closed = 1;
        end else begin
          admit_byte(prev, pcs_pkg::CH_LF);
        end
      end
      if (!closed) begin
        if (b == pcs_pkg::CH_LF) held_lf = 1;
        else admit_byte(p, b);
      end
    end else if (!ws) begin
      chunk_base = p;
      in_para    = 1;
      held_lf    = 0;
      cut_valid  = 0;
      cut_at     = 0;
      admit_byte(p, b);
    end
    if (pos_count < 64'hFFFF_FFFF) pos_count++;
    if (last) begin
      if (in_para) begin
        if (held_lf) begin
          held_lf = 0;
          admit_byte(p, pcs_pkg::CH_LF);
        end
        close_para(pos_count);
      end
      add_beat(pcs_pkg::KIND_DOC_END, 0, 0, 0, chunks_kept);
      clear_document();
    end
    if (step_beats.size() > 0) begin
      tail          = step_beats[step_beats.size() - 1];
      tail.run_last = 1'b1;
      step_beats[step_beats.size() - 1] = tail;
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, before the DUT's
  // own registers move. A popped beat is scored first, then an accepted byte
  // is run through the model; a byte's beats can never leave in its own
  // cycle, so that order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    chunk_beat_t want;
    chunk_beat_t typed;
    if (rst_n && out_pop && !out_empty) begin
      beats_seen++;
      if (pending_chunks.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual kind %0d off %0d len %0d",
                 $time, out_result_kind, out_chunk_offset, out_chunk_length);
        failures++;
      end else begin
        want = pending_chunks.pop_front();
        check_field("result_kind",  want.kind,     out_result_kind);
        check_field("chunk_offset", want.offset,   out_chunk_offset);
        check_field("chunk_length", want.length,   out_chunk_length);
        check_field("chunk_number", want.number,   out_chunk_number);
        check_field("total_chunks", want.total,    out_total_chunks);
        check_field("run_last",     want.run_last, out_run_last);
      end
    end
    if (rst_n && in_push && !in_full) begin
      bytes_taken++;
      if (in_last_byte) docs_ended++;
      // The model runs on every byte so its state stays in step; typed rows
      // replace its beats with the hand-written outcome.
      split_byte(in_data_byte, in_last_byte);
      case (drv_kind)
        ROW_QUIET: begin
        end
        ROW_DOC_END: begin
          typed.kind     = pcs_pkg::KIND_DOC_END;
          typed.offset   = '0;
          typed.length   = '0;
          typed.number   = '0;
          typed.total    = 32'(drv_total);
          typed.run_last = 1'b1;
          pending_chunks.push_back(typed);
        end
        default: begin
          foreach (step_beats[i]) pending_chunks.push_back(step_beats[i]);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Pop follows a mode that is redrawn at random intervals: free
  // flowing, one pop in three, coin flips, or long stalls with short windows.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (pop_epoch == 0) begin
      pop_mode  = $urandom_range(0, 3);
      pop_epoch = $urandom_range(16, 80);
    end else begin
      pop_epoch--;
    end
    pop_tick++;
    case (pop_mode)
      0:       out_pop = 1'b1;
      1:       out_pop = (pop_tick % 3 == 0);
      2:       out_pop = $urandom_range(0, 1);
      default: out_pop = (pop_tick % 16 >= 12);
    endcase
  end

  // --------------------------------------------------------------------------
  // Drivers. All inputs move at the falling edge only.
  // --------------------------------------------------------------------------

  // Presents one byte and holds it until the rising edge that takes it. Push
  // stays high on return; the next call or a pause takes it from there.
  task automatic send_byte(logic [7:0] b, logic last, row_kind_e kind,
                           logic [15:0] total);
    @(negedge clk);
    in_push      = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    drv_kind     = kind;
    drv_total    = total;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_push = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Register writes only happen with the block drained: nothing owed, and
  // enough extra cycles for a byte that produced no beat to clear the engine.
  task automatic write_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcs_pkg::CFG_W-1:0] val);
    pause_input(0);
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == pcs_pkg::CFG_IDX_MAX_LEN) span_max = val;
    else if (idx == pcs_pkg::CFG_IDX_MIN_LEN) keep_min = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table. It opens on the reset limits, where short paragraphs are
  // all dropped and the document-end totals can be typed in. It then runs
  // with the max below its floor (clamped to two), so a hard cut, a paragraph
  // ended by two line feeds and a carriage return between paragraphs show up.
  // A max of four then shows a cut at a period and a held-back line feed
  // taken in by the last byte, and both registers at all ones close it out.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [25] = '{
    '{ROW_QUIET,   pcs_pkg::CH_SPACE,        1'b0, 16'd0},
    '{ROW_QUIET,   pcs_pkg::CH_TAB,          1'b0, 16'd0},
    '{ROW_QUIET,   8'h00,                    1'b0, 16'd0},
    '{ROW_DOC_END, 8'hFF,                    1'b1, 16'd0},
    '{ROW_CFG,     pcs_pkg::CFG_IDX_MAX_LEN, 1'b0, 16'd1},
    '{ROW_CFG,     pcs_pkg::CFG_IDX_MIN_LEN, 1'b0, 16'd0},
    '{ROW_MODEL,   "a",                      1'b0, 16'd0},
    '{ROW_MODEL,   "b",                      1'b0, 16'd0},
    '{ROW_MODEL,   "c",                      1'b0, 16'd0},
    '{ROW_MODEL,   pcs_pkg::CH_LF,           1'b0, 16'd0},
    '{ROW_MODEL,   pcs_pkg::CH_LF,           1'b0, 16'd0},
    '{ROW_MODEL,   pcs_pkg::CH_CR,           1'b0, 16'd0},
    '{ROW_MODEL,   "d",                      1'b1, 16'd0},
    '{ROW_CFG,     pcs_pkg::CFG_IDX_MAX_LEN, 1'b0, 16'd4},
    '{ROW_MODEL,   "e",                      1'b0, 16'd0},
    '{ROW_MODEL,   "f",                      1'b0, 16'd0},
    '{ROW_MODEL,   "g",                      1'b0, 16'd0},
    '{ROW_MODEL,   pcs_pkg::CH_DOT,          1'b0, 16'd0},
    '{ROW_MODEL,   "h",                      1'b0, 16'd0},
    '{ROW_MODEL,   pcs_pkg::CH_LF,           1'b0, 16'd0},
    '{ROW_MODEL,   "i",                      1'b1, 16'd0},
    '{ROW_CFG,     pcs_pkg::CFG_IDX_MAX_LEN, 1'b0, 16'hFFFF},
    '{ROW_CFG,     pcs_pkg::CFG_IDX_MIN_LEN, 1'b0, 16'hFFFF},
    '{ROW_QUIET,   "j",                      1'b0, 16'd0},
    '{ROW_DOC_END, "k",                      1'b1, 16'd0}
  };

  // Limits per random phase. Phases do not end documents on purpose, so a
  // new limit often lands in the middle of an open paragraph.
  logic [15:0] phase_max [RANDOM_PHASES] =
    '{16'd2, 16'd3, 16'd6, 16'd12, 16'd32768, 16'd0, 16'd24, 16'd5};
  logic [15:0] phase_min [RANDOM_PHASES] =
    '{16'd0, 16'd1, 16'd2, 16'd0, 16'd0, 16'd3, 16'd32768, 16'd0};

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_flow
    int          sent;
    int          burst;
    int          roll;
    int          share;
    logic [7:0]  b;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    drv_kind     = ROW_MODEL;
    drv_total    = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].code, directed_rows[i].value);
      else
        send_byte(directed_rows[i].code, directed_rows[i].last,
                  directed_rows[i].kind, directed_rows[i].value);
    end

    // Random text: mostly letters with periods and line breaks mixed in so
    // paragraphs form and get cut, plus stray whitespace and raw bytes.
    share = RANDOM_ITEMS / RANDOM_PHASES;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(pcs_pkg::CFG_IDX_MAX_LEN, phase_max[ph]);
      write_reg(pcs_pkg::CFG_IDX_MIN_LEN, phase_min[ph]);
      sent = 0;
      while (sent < share) begin
        burst = $urandom_range(1, 12);
        if (burst > share - sent) burst = share - sent;
        repeat (burst) begin
          roll = $urandom_range(0, 99);
          if (roll < 50)      b = 8'($urandom_range(8'h61, 8'h7A));
          else if (roll < 62) b = pcs_pkg::CH_DOT;
          else if (roll < 76) b = pcs_pkg::CH_LF;
          else if (roll < 81) b = pcs_pkg::CH_CR;
          else if (roll < 88) b = pcs_pkg::CH_SPACE;
          else if (roll < 91) b = pcs_pkg::CH_TAB;
          else                b = 8'($urandom_range(0, 255));
          send_byte(b, ($urandom_range(0, 24) == 0), ROW_MODEL, 16'd0);
          sent++;
        end
        // Roughly a quarter of bursts run straight into the next one.
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 6));
      end
    end

    // Close the last document so its summary beat is scored too.
    send_byte("z", 1'b1, ROW_MODEL, 16'd0);

    pause_input(0);
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d bytes over %0d documents and %0d register writes.",
             bytes_taken, docs_ended, reg_writes);
    $display("Scored %0d result beats, %0d field errors.", beats_seen, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run at these item counts.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
